/* rtl/core/i2cbm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, command codes and segment tables for the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes carried on the input stream.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WACK  = 3'd4;
    localparam logic [2:0] OP_SACK  = 3'd5;

    // Width of the delay register as seen on the configuration port.
    localparam int unsigned CFG_W = 16;

    // Delay register value after reset.
    localparam logic [CFG_W-1:0] DELAY_RESET = 16'd5;

    // Bit position of the most significant data bit.
    localparam logic [2:0] TOP_BIT = 3'd7;

    // Pin levels and bit position for one waveform segment.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [2:0] bidx;
        logic       bidx_we;
    } seg_t;

    // Registered view of the engine that feeds the result word.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } status_t;

    // Index of the last segment of each command.
    function automatic logic [4:0] seg_count(input logic [2:0] op);
        logic [4:0] cnt;
        case (op)
            OP_START: cnt = 5'd3;
            OP_STOP:  cnt = 5'd2;
            OP_WRITE: cnt = 5'd25;
            OP_READ:  cnt = 5'd16;
            OP_WACK:  cnt = 5'd2;
            default:  cnt = 5'd4;
        endcase
        return cnt;
    endfunction

endpackage

/* rtl/core/i2c_bit_level_master.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Bit-level I2C master driven one tick per stream word.
// The result word for a tick is registered and is valid in the cycle after the word is accepted.
// Throughput: one tick per cycle while m_tready does not hold the result; the sequencer state updates once per tick.
// The result register frees as it is read, so a new tick is taken in the same cycle.
// Reset (rst_n low, asynchronous) idles the bus: SCL and SDA released, delay set to 5.
// ----------------------------------------------------------------------------
module i2c_bit_level_master
#(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: delay_ticks.
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    // Input ticks.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tx_byte[7:0], ack_value[8], sda_in[9], zero[15:10]
    input  logic [3:0]  s_tuser,   // cmd_valid[0], op[3:1]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                                   // rx_byte[11:4], ack_seen[12], zero[15:13]
);

    logic [i2cbm_pkg::CFG_W-1:0] delay_reg;
    logic                        m_tvalid_reg;
    logic                        accept;
    i2cbm_pkg::status_t          status;

    // A word is taken when the result register is empty or being read.
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    // Delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= i2cbm_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            delay_reg <= cfg_data;
        end
    end

    i2cbm_seq #(.DELAY_WIDTH(DELAY_WIDTH)) u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .cmd_valid   (s_tuser[0]),
        .op          (s_tuser[3:1]),
        .tx_byte     (s_tdata[7:0]),
        .ack_value   (s_tdata[8]),
        .sda_in      (s_tdata[9]),
        .delay_ticks (delay_reg),
        .status      (status)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result word packing.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, status.ack, status.rx, status.done, status.busy,
                       status.sda, status.scl};

endmodule

/* rtl/core/i2cbm_seg_decode.sv */
// ----------------------------------------------------------------------------
// i2cbm_seg_decode
// Maps a command and segment number to the SCL and SDA levels of that segment.
// ----------------------------------------------------------------------------
module i2cbm_seg_decode
(
    input  logic [2:0]       op,
    input  logic [4:0]       phase,
    input  logic [7:0]       shift_byte,
    output i2cbm_pkg::seg_t  seg
);

    // Division by three of a value below 24 as a multiply and shift.
    localparam logic [8:0] RECIP_THIRD = 9'd11;
    localparam int unsigned RECIP_SHIFT = 5;

    logic [4:0] wr_k;
    logic [8:0] wr_prod;
    logic [2:0] wr_q;
    logic [4:0] wr_r;
    logic [2:0] wr_bidx;
    logic [4:0] rd_k;

    // Write segments: k = phase - 2 splits into bit number and sub-phase.
    always_comb
    begin
        wr_k    = phase - 5'd2;
        wr_prod = 9'(wr_k) * RECIP_THIRD;
        wr_q    = wr_prod[RECIP_SHIFT+2:RECIP_SHIFT];
        wr_r    = wr_k - {1'b0, wr_q, 1'b0} - {2'b00, wr_q};
        wr_bidx = i2cbm_pkg::TOP_BIT - wr_q;
        rd_k    = phase - 5'd1;
    end

    // Segment table per command.
    always_comb
    begin
        seg.scl     = 1'b1;
        seg.sda     = 1'b1;
        seg.bidx    = i2cbm_pkg::TOP_BIT;
        seg.bidx_we = 1'b0;
        unique case (op)
            i2cbm_pkg::OP_START:
            begin
                seg.scl = (phase <= 5'd2);
                seg.sda = (phase == 5'd1);
            end
            i2cbm_pkg::OP_STOP:
            begin
                seg.scl = 1'b1;
                seg.sda = (phase == 5'd2);
            end
            i2cbm_pkg::OP_WRITE:
            begin
                if (phase <= 5'd1)
                begin
                    seg.scl = 1'b0;
                    seg.sda = 1'b0;
                end
                else
                begin
                    seg.bidx    = wr_bidx;
                    seg.bidx_we = 1'b1;
                    seg.scl     = (wr_r == 5'd1);
                    seg.sda     = shift_byte[wr_bidx];
                end
            end
            i2cbm_pkg::OP_READ:
            begin
                seg.bidx    = i2cbm_pkg::TOP_BIT - rd_k[3:1];
                seg.bidx_we = 1'b1;
                seg.scl     = ~rd_k[0];
                seg.sda     = 1'b1;
            end
            i2cbm_pkg::OP_WACK:
            begin
                seg.scl = (phase == 5'd1);
                seg.sda = 1'b1;
            end
            default:
            begin
                seg.scl = (phase == 5'd3);
                seg.sda = (phase == 5'd1) ? 1'b0 : shift_byte[0];
            end
        endcase
    end

endmodule

/* rtl/core/i2cbm_seq.sv */
// ----------------------------------------------------------------------------
// i2cbm_seq
// Tick sequencer: holds the bus state and advances it by one tick per word.
// ----------------------------------------------------------------------------
module i2cbm_seq
#(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          cmd_valid,
    input  logic [2:0]                    op,
    input  logic [7:0]                    tx_byte,
    input  logic                          ack_value,
    input  logic                          sda_in,
    input  logic [i2cbm_pkg::CFG_W-1:0]   delay_ticks,
    output i2cbm_pkg::status_t            status
);

    logic [2:0]             op_reg,    op_next;
    logic [4:0]             phase_reg, phase_next;
    logic [2:0]             bidx_reg,  bidx_next;
    logic [7:0]             shift_reg, shift_next;
    logic [DELAY_WIDTH-1:0] count_reg, count_next;
    logic                   scl_reg,   scl_next;
    logic                   sda_reg,   sda_next;
    logic                   ack_reg,   ack_next;
    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [7:0]             rx_reg,    rx_next;

    logic [DELAY_WIDTH+i2cbm_pkg::CFG_W-1:0] delay_ext;
    logic [DELAY_WIDTH-1:0] hold_len;
    logic                   start;
    logic [7:0]             start_shift;
    logic [7:0]             shift_smp;
    logic [2:0]             dec_op;
    logic [4:0]             dec_phase;
    logic [7:0]             dec_shift;
    logic                   enter;
    i2cbm_pkg::seg_t        seg;

    // Hold length: delay reduced to the counter width, zero treated as one.
    always_comb
    begin
        delay_ext = {{DELAY_WIDTH{1'b0}}, delay_ticks};
        hold_len  = delay_ext[DELAY_WIDTH-1:0];
        if (hold_len == '0)
        begin
            hold_len = {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    // Command start and the inputs of the segment decoder.
    always_comb
    begin
        start = ~busy_reg && cmd_valid && (op <= i2cbm_pkg::OP_SACK);
        if (op == i2cbm_pkg::OP_WRITE)
        begin
            start_shift = tx_byte;
        end
        else if (op == i2cbm_pkg::OP_SACK)
        begin
            start_shift = {7'd0, ack_value};
        end
        else
        begin
            start_shift = 8'd0;
        end
        dec_op    = start ? op : op_reg;
        dec_phase = start ? 5'd1 : (phase_reg + 5'd1);
        dec_shift = start ? start_shift : shift_reg;
        shift_smp = shift_reg | (8'({7'd0, sda_in}) << bidx_reg);
    end

    i2cbm_seg_decode u_seg_decode
    (
        .op         (dec_op),
        .phase      (dec_phase),
        .shift_byte (dec_shift),
        .seg        (seg)
    );

    // One tick of the command sequence.
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        bidx_next  = bidx_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        busy_next  = busy_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        enter      = 1'b0;
        if (busy_reg)
        begin
            if (count_reg > {{(DELAY_WIDTH-1){1'b0}}, 1'b1})
            begin
                count_next = count_reg - {{(DELAY_WIDTH-1){1'b0}}, 1'b1};
            end
            else
            begin
                count_next = '0;
                // Read bits are sampled at the end of each SCL-high segment.
                if (op_reg == i2cbm_pkg::OP_READ && phase_reg[0])
                begin
                    shift_next = shift_smp;
                end
                if (op_reg == i2cbm_pkg::OP_WACK && phase_reg == 5'd1)
                begin
                    ack_next = sda_in;
                end
                if (phase_reg >= i2cbm_pkg::seg_count(op_reg))
                begin
                    if (op_reg == i2cbm_pkg::OP_READ)
                    begin
                        rx_next = shift_next;
                    end
                    busy_next  = 1'b0;
                    phase_next = 5'd0;
                    done_next  = 1'b1;
                end
                else
                begin
                    phase_next = phase_reg + 5'd1;
                    enter      = 1'b1;
                end
            end
        end
        else if (start)
        begin
            op_next    = op;
            phase_next = 5'd1;
            bidx_next  = i2cbm_pkg::TOP_BIT;
            shift_next = start_shift;
            busy_next  = 1'b1;
            enter      = 1'b1;
        end
        // Entering a segment sets the pins and reloads the hold counter.
        if (enter)
        begin
            scl_next   = seg.scl;
            sda_next   = seg.sda;
            count_next = hold_len;
            if (seg.bidx_we)
            begin
                bidx_next = seg.bidx;
            end
        end
    end

    // State registers, advanced once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= i2cbm_pkg::OP_START;
            phase_reg <= 5'd0;
            bidx_reg  <= i2cbm_pkg::TOP_BIT;
            shift_reg <= 8'd0;
            count_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (advance)
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            rx_reg    <= rx_next;
        end
    end

    // The registered state is the result of the last accepted tick.
    always_comb
    begin
        status.scl  = scl_reg;
        status.sda  = sda_reg;
        status.busy = busy_reg;
        status.done = done_reg;
        status.rx   = rx_reg;
        status.ack  = ack_reg;
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit-level I2C master. Every stream word is one
// tick and returns one status word. A local model of the sequencer predicts
// the pin levels, busy and done flags, the read byte and the sampled
// acknowledge for every tick. The checker compares each status word against
// the oldest prediction. Directed commands come first, then random bus
// transactions run under several delay settings.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    // Sources for the SDA level that the bench feeds back on each tick.
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    // Command codes outside the defined set.
    localparam logic [2:0] OP_BAD_LO = 3'd6;
    localparam logic [2:0] OP_BAD_HI = 3'd7;

    // A long delay that still keeps the run short.
    localparam logic [15:0] DELAY_LONG = 16'd20;

    // Ticks sent in each random phase before it winds down.
    localparam int unsigned PHASE_TICKS = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // tx_byte[7:0], ack_value[8], sda_in[9], zero[15:10]
    logic [3:0]  s_tuser;   // cmd_valid[0], op[3:1]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                            // rx_byte[11:4], ack_seen[12], zero[15:13]

    // Random idling on both sides is turned off for one long stretch.
    bit gaps_on;
    int errors;
    int unsigned ticks_sent;

    // Expected status words, oldest first.
    status_t pin_status_q[$];

    // Local copy of the sequencer state.
    logic [15:0] seq_delay;
    logic [2:0]  seq_op;
    logic [4:0]  seq_phase;
    logic [2:0]  seq_bit;
    logic [7:0]  seq_shift;
    int unsigned seq_hold;
    logic        seq_scl;
    logic        seq_sda;
    logic        seq_ack;
    logic        seq_busy;
    logic [7:0]  seq_rx;

    i2c_bit_level_master dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Result-side backpressure, changed on the falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !gaps_on || ($urandom_range(99) >= 30);
        end
    end

    // Hard limit on the run.
    initial
    begin
        #(64'd20_000_000);
        $display("tb: FAIL");
        $finish;
    end

    // Index of the last segment of each command.
    function automatic int last_segment(input logic [2:0] op);
        case (op)
            OP_START: return 3;
            OP_STOP:  return 2;
            OP_WRITE: return 25;
            OP_READ:  return 16;
            OP_WACK:  return 2;
            default:  return 4;
        endcase
    endfunction

    // Sets the pins for the current segment and reloads the hold counter.
    function automatic void load_segment();
        int k;
        case (seq_op)
            OP_START:
            begin
                seq_scl = (seq_phase <= 2);
                seq_sda = (seq_phase == 1);
            end
            OP_STOP:
            begin
                seq_scl = 1'b1;
                seq_sda = (seq_phase == 2);
            end
            OP_WRITE:
            begin
                if (seq_phase <= 1)
                begin
                    seq_scl = 1'b0;
                    seq_sda = 1'b0;
                end
                else
                begin
                    k = int'(seq_phase) - 2;
                    seq_bit = 3'(7 - k / 3);
                    seq_scl = (k % 3 == 1);
                    seq_sda = seq_shift[seq_bit];
                end
            end
            OP_READ:
            begin
                k = int'(seq_phase) - 1;
                seq_bit = 3'(7 - k / 2);
                seq_scl = (k % 2 == 0);
                seq_sda = 1'b1;
            end
            OP_WACK:
            begin
                seq_scl = (seq_phase == 1);
                seq_sda = 1'b1;
            end
            default:
            begin
                seq_scl = (seq_phase == 3);
                seq_sda = (seq_phase == 1) ? 1'b0 : seq_shift[0];
            end
        endcase
        // A zero delay still holds each segment for one tick.
        seq_hold = (seq_delay == 16'd0) ? 1 : int'(seq_delay);
    endfunction

    // Advances the sequencer by one tick and returns the status it shows.
    function automatic status_t bus_engine_tick(input logic cmd_valid, input logic [2:0] op,
                                                input logic [7:0] tx, input logic ackv,
                                                input logic sda);
        status_t r;
        logic done;
        done = 1'b0;
        if (seq_busy)
        begin
            if (seq_hold > 1)
            begin
                seq_hold--;
            end
            else
            begin
                seq_hold = 0;
                // SDA is sampled on the tick the high SCL segment ends.
                if (seq_op == OP_READ && ((seq_phase - 5'd1) % 2 == 0))
                    seq_shift[seq_bit] = seq_shift[seq_bit] | sda;
                if (seq_op == OP_WACK && seq_phase == 1)
                    seq_ack = sda;
                if (int'(seq_phase) >= last_segment(seq_op))
                begin
                    if (seq_op == OP_READ)
                        seq_rx = seq_shift;
                    seq_busy = 1'b0;
                    seq_phase = 5'd0;
                    done = 1'b1;
                end
                else
                begin
                    seq_phase++;
                    load_segment();
                end
            end
        end
        else if (cmd_valid && op <= OP_SACK)
        begin
            seq_op = op;
            seq_phase = 5'd1;
            seq_bit = TOP_BIT;
            if (op == OP_WRITE)
                seq_shift = tx;
            else if (op == OP_SACK)
                seq_shift = {7'd0, ackv};
            else
                seq_shift = 8'd0;
            seq_busy = 1'b1;
            load_segment();
        end
        r.scl = seq_scl;
        r.sda = seq_sda;
        r.busy = seq_busy;
        r.done = done;
        r.rx = seq_rx;
        r.ack = seq_ack;
        return r;
    endfunction

    // Sends one tick word and records the status it should produce.
    task automatic send_tick(input logic cmd_valid, input logic [2:0] op, input logic [7:0] tx,
                             input logic ackv, input logic sda);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, sda, ackv, tx};
        s_tuser <= {op, cmd_valid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pin_status_q.push_back(bus_engine_tick(cmd_valid, op, tx, ackv, sda));
        ticks_sent++;
    endtask

    // Issues one command, then keeps ticking until the sequence ends.
    // Ticks sent while busy carry random commands, which must be ignored.
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ackv,
                           input int level_src);
        logic sda;
        sda = (level_src == SDA_RANDOM) ? 1'($urandom_range(1)) : (level_src == SDA_HIGH);
        send_tick(1'b1, op, tx, ackv, sda);
        while (seq_busy)
        begin
            sda = (level_src == SDA_RANDOM) ? 1'($urandom_range(1)) : (level_src == SDA_HIGH);
            send_tick(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
                      1'($urandom_range(1)), sda);
        end
    endtask

    // Stops sending and waits until every predicted word has been checked.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pin_status_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes the delay register while the block is idle.
    task automatic set_delay(input logic [15:0] value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        seq_delay = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Compares every accepted status word with the oldest prediction.
    initial
    begin
        status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pin_status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: status word with nothing expected, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = pin_status_q.pop_front();
                    check_field("scl_level", {7'd0, want.scl}, {7'd0, m_tdata[0]});
                    check_field("sda_level", {7'd0, want.sda}, {7'd0, m_tdata[1]});
                    check_field("busy_res", {7'd0, want.busy}, {7'd0, m_tdata[2]});
                    check_field("done_res", {7'd0, want.done}, {7'd0, m_tdata[3]});
                    check_field("rx_byte", want.rx, m_tdata[11:4]);
                    check_field("ack_seen", {7'd0, want.ack}, {7'd0, m_tdata[12]});
                end
            end
        end
    end

    // The delay after reset is five ticks per segment.
    task automatic test_reset_delay();
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    // Zero acts as one, then the smallest real delay and a long one.
    task automatic test_delay_extremes();
        set_delay(16'd0);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
        set_delay(16'd1);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
        set_delay(DELAY_LONG);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    // Every command at least once, with all-ones and all-zeros data, and undefined codes.
    task automatic test_each_command();
        set_delay(16'd2);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
        run_cmd(OP_WACK, 8'h00, 1'b0, SDA_HIGH);
        run_cmd(OP_WRITE, 8'h00, 1'b1, SDA_RANDOM);
        run_cmd(OP_WACK, 8'h00, 1'b0, SDA_LOW);
        run_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH);
        run_cmd(OP_SACK, 8'h00, 1'b1, SDA_RANDOM);
        run_cmd(OP_READ, 8'hFF, 1'b1, SDA_LOW);
        run_cmd(OP_SACK, 8'hFF, 1'b0, SDA_RANDOM);
        run_cmd(OP_BAD_LO, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(OP_BAD_HI, 8'hFF, 1'b1, SDA_RANDOM);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    // Mostly complete transactions with random data, mixed with stray words.
    task automatic test_random_transfers();
        int unsigned stop_at;
        int nbytes;
        for (int phase_set = 0; phase_set < 4; phase_set++)
        begin
            case (phase_set)
                0: set_delay(16'd1);
                1: set_delay(16'd1);
                2: set_delay(16'd2);
                default: set_delay(16'($urandom_range(2, 1)));
            endcase
            // One whole phase runs with no idling on either side.
            gaps_on = (phase_set != 2);
            stop_at = ticks_sent + PHASE_TICKS;
            while (ticks_sent < stop_at)
            begin
                if ($urandom_range(99) < 85)
                begin
                    run_cmd(OP_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                    nbytes = $urandom_range(2, 1);
                    for (int n = 0; n < nbytes; n++)
                    begin
                        if ($urandom_range(1))
                        begin
                            run_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                            run_cmd(OP_WACK, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                        end
                        else
                        begin
                            run_cmd(OP_READ, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                            run_cmd(OP_SACK, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                        end
                    end
                    run_cmd(OP_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM);
                end
                else if ($urandom_range(1))
                begin
                    // A lone command of any code, defined or not.
                    run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                            SDA_RANDOM);
                end
                else
                begin
                    // An idle tick with no command.
                    send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                // Now and then the sender holds off until all status has come back.
                if ($urandom_range(99) < 20)
                    drain();
            end
        end
        gaps_on = 1'b1;
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 16'd0;
        s_tvalid = 1'b0;
        s_tdata = 16'd0;
        s_tuser = 4'd0;
        gaps_on = 1'b1;
        errors = 0;
        ticks_sent = 0;

        // Sequencer state after reset.
        seq_delay = DELAY_RESET;
        seq_op = OP_START;
        seq_phase = 5'd0;
        seq_bit = TOP_BIT;
        seq_shift = 8'd0;
        seq_hold = 0;
        seq_scl = 1'b1;
        seq_sda = 1'b1;
        seq_ack = 1'b0;
        seq_busy = 1'b0;
        seq_rx = 8'd0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_delay();
        test_delay_extremes();
        test_each_command();
        test_random_transfers();

        // Wait for the last words, then a little longer for strays.
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pin_status_q.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
